FILE: src/u8e1_pkg.sv
// Shared types and constants for the 8E1 half-duplex UART.
// No dependencies; all other files import this package.
`timescale 1ns / 1ps

package u8e1_pkg;

  // Frame layout
  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = DATA_BITS + 2;     // start + data + parity count-down
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);

  // Field and register widths
  localparam int TICK_W = 16;
  localparam int BYTE_W = 8;

  // Config port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_REG_BIT_PERIOD  = 1'b0;
  localparam logic CFG_REG_START_DELAY = 1'b1;
  localparam logic [TICK_W-1:0] BIT_PERIOD_RST  = 16'd416;
  localparam logic [TICK_W-1:0] START_DELAY_RST = 16'd624;

  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [BITS_W-1:0]    bits_t;
  typedef logic [TICK_W-1:0]    tick_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TX,
    MODE_RX
  } mode_t;

  typedef struct packed {
    tick_t bit_period;
    tick_t start_delay;
  } cfg_t;

  typedef struct packed {
    logic              rx_line;
    logic              tx_request;
    logic [BYTE_W-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_busy;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              parity_error;
    logic              parity_error_sticky;
  } res_t;

endpackage

FILE: src/u8e1_if.sv
// Valid/ready channel interfaces for the UART sample and result words.
// Depends on u8e1_pkg for field widths.
`timescale 1ns / 1ps

interface u8e1_in_if;
  import u8e1_pkg::*;

  logic              valid;
  logic              ready;
  logic              rx_line;
  logic              tx_request;
  logic [BYTE_W-1:0] tx_byte;

  modport source (output valid, output rx_line, output tx_request, output tx_byte,
                  input ready);
  modport sink   (input valid, input rx_line, input tx_request, input tx_byte,
                  output ready);
endinterface

interface u8e1_out_if;
  import u8e1_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_busy;
  logic              rx_busy;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_byte;
  logic              parity_error;
  logic              parity_error_sticky;

  modport source (output valid, output tx_line, output tx_busy, output rx_busy,
                  output rx_valid, output rx_byte, output parity_error,
                  output parity_error_sticky, input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input rx_busy,
                  input rx_valid, input rx_byte, input parity_error,
                  input parity_error_sticky, output ready);
endinterface

FILE: src/u8e1_cfg.sv
// APB-style register file: bit_period and start_delay.
// Depends on u8e1_pkg.
`timescale 1ns / 1ps

module u8e1_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [u8e1_pkg::CFG_AW-1:0] paddr,
  input  logic [u8e1_pkg::CFG_DW-1:0] pwdata,
  output logic [u8e1_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output u8e1_pkg::cfg_t             cfg
);
  import u8e1_pkg::*;

  tick_t bit_period_r;
  tick_t start_delay_r;
  logic  reg_idx;
  logic  wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      start_delay_r <= START_DELAY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_REG_BIT_PERIOD:  bit_period_r  <= pwdata[TICK_W-1:0];
        CFG_REG_START_DELAY: start_delay_r <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      CFG_REG_BIT_PERIOD:  prdata = CFG_DW'(bit_period_r);
      CFG_REG_START_DELAY: prdata = CFG_DW'(start_delay_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.bit_period  = bit_period_r;
  assign cfg.start_delay = start_delay_r;

endmodule

FILE: src/u8e1_core.sv
// Frame engine: bit timer, TX/RX sequencer, shift register and parity.
// One tick per accepted word. Depends on u8e1_pkg.
`timescale 1ns / 1ps

module u8e1_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  u8e1_pkg::item_t item,
  input  u8e1_pkg::cfg_t  cfg,
  output u8e1_pkg::res_t  res
);
  import u8e1_pkg::*;

  localparam bits_t FRAME_CNT = BITS_W'(FRAME_BITS);
  localparam bits_t CNT_ONE   = BITS_W'(1);
  localparam bits_t CNT_TWO   = BITS_W'(2);
  localparam bits_t CNT_THREE = BITS_W'(3);

  mode_t             mode_r,   mode_nxt;
  tick_t             tick_r,   tick_nxt;
  bits_t             bits_r,   bits_nxt;
  data_t             shift_r,  shift_nxt;
  logic              par_r,    par_nxt;
  logic              line_r,   line_nxt;
  logic              rxprev_r, rxprev_nxt;
  logic              sticky_r, sticky_nxt;
  logic [BYTE_W-1:0] hold_r,   hold_nxt;
  logic              valid_nxt;
  logic              perr_nxt;
  tick_t             target;
  logic              fire;
  data_t             tx_data;

  assign tx_data = data_t'(item.tx_byte);
  // RX uses start_delay for the first interval only
  assign target  = (mode_r == MODE_RX && bits_r == FRAME_CNT) ? cfg.start_delay
                                                               : cfg.bit_period;
  assign fire    = (tick_r == target);

  always_comb begin
    mode_nxt   = mode_r;
    tick_nxt   = tick_r;
    bits_nxt   = bits_r;
    shift_nxt  = shift_r;
    par_nxt    = par_r;
    line_nxt   = line_r;
    sticky_nxt = sticky_r;
    hold_nxt   = hold_r;
    rxprev_nxt = item.rx_line;
    valid_nxt  = 1'b0;
    perr_nxt   = 1'b0;

    unique case (mode_r)
      MODE_TX: begin
        tick_nxt = fire ? '0 : tick_r + 1'b1;
        if (fire) begin
          if (bits_r == FRAME_CNT) begin
            line_nxt = 1'b0;
            bits_nxt = bits_r - 1'b1;
          end else if (bits_r >= CNT_TWO) begin
            line_nxt  = shift_r[0];
            shift_nxt = shift_r >> 1;
            bits_nxt  = bits_r - 1'b1;
          end else if (bits_r == CNT_ONE) begin
            line_nxt = par_r;
            bits_nxt = bits_r - 1'b1;
          end else begin
            line_nxt = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_RX: begin
        tick_nxt = fire ? '0 : tick_r + 1'b1;
        if (fire) begin
          if (bits_r >= CNT_THREE) begin
            shift_nxt = {item.rx_line, shift_r[DATA_BITS-1:1]};
            par_nxt   = par_r ^ item.rx_line;
            bits_nxt  = bits_r - 1'b1;
          end else if (bits_r == CNT_TWO) begin
            par_nxt  = par_r ^ item.rx_line;
            bits_nxt = bits_r - 1'b1;
          end else begin
            hold_nxt   = BYTE_W'(shift_r);
            valid_nxt  = 1'b1;
            perr_nxt   = par_r;
            sticky_nxt = sticky_r | par_r;
            mode_nxt   = MODE_IDLE;
            bits_nxt   = '0;
          end
        end
      end
      default: begin
        if (item.tx_request) begin
          mode_nxt  = MODE_TX;
          tick_nxt  = '0;
          bits_nxt  = FRAME_CNT;
          shift_nxt = tx_data;
          par_nxt   = ^tx_data;
        end else if (rxprev_r && !item.rx_line) begin
          mode_nxt  = MODE_RX;
          tick_nxt  = '0;
          bits_nxt  = FRAME_CNT;
          shift_nxt = '0;
          par_nxt   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      tick_r   <= '0;
      bits_r   <= '0;
      shift_r  <= '0;
      par_r    <= 1'b0;
      line_r   <= 1'b1;
      rxprev_r <= 1'b1;
      sticky_r <= 1'b0;
      hold_r   <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      tick_r   <= tick_nxt;
      bits_r   <= bits_nxt;
      shift_r  <= shift_nxt;
      par_r    <= par_nxt;
      line_r   <= line_nxt;
      rxprev_r <= rxprev_nxt;
      sticky_r <= sticky_nxt;
      hold_r   <= hold_nxt;
    end
  end

  // Result word reflects post-tick state
  always_comb begin
    res.tx_line             = line_nxt;
    res.tx_busy             = (mode_nxt == MODE_TX);
    res.rx_busy             = (mode_nxt == MODE_RX);
    res.rx_valid            = valid_nxt;
    res.rx_byte             = hold_nxt;
    res.parity_error        = perr_nxt;
    res.parity_error_sticky = sticky_nxt;
  end

endmodule

FILE: src/u8e1_out_reg.sv
// Result register with valid/ready: holds one result word until taken.
// Depends on u8e1_pkg.
`timescale 1ns / 1ps

module u8e1_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  u8e1_pkg::res_t res_in,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           can_load,
  output u8e1_pkg::res_t res_out
);
  import u8e1_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

FILE: src/uart_8e1_half_duplex.sv
// Half-duplex UART, 8 data bits LSB first, even parity, 1 stop bit.
// The result word for a tick is registered and shown the cycle after accept.
// Throughput: one tick word per cycle while the result register is empty or being drained;
//   the frame engine advances only on an accepted word and stalls while a result is held.
// Reset (rst_n low, synchronous): idle, TX line high, counters and sticky error cleared,
//   registers back to bit_period 416 / start_delay 624, result register empty.
// Depends on u8e1_pkg, u8e1_if, u8e1_cfg, u8e1_core, u8e1_out_reg.
`timescale 1ns / 1ps

module uart_8e1_half_duplex (
  input  logic                        clk,
  input  logic                        rst_n,
  u8e1_in_if.sink                     in_ch,
  u8e1_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [u8e1_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [u8e1_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [u8e1_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import u8e1_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res_now;
  res_t  res_held;
  logic  can_load;
  logic  step;

  // Register file; the user must change values only while the link is idle (not enforced here)
  u8e1_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // A tick word is consumed whenever the result register can take its result
  assign in_ch.ready     = can_load;
  assign step            = in_ch.valid && can_load;
  assign item.rx_line    = in_ch.rx_line;
  assign item.tx_request = in_ch.tx_request;
  assign item.tx_byte    = in_ch.tx_byte;

  // Frame engine: state updates on the accept edge, result computed in the same pass
  u8e1_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .cfg   (cfg),
    .res   (res_now)
  );

  // Result register decouples downstream stalls from the engine
  u8e1_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_now),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_load  (can_load),
    .res_out   (res_held)
  );

  assign out_ch.tx_line             = res_held.tx_line;
  assign out_ch.tx_busy             = res_held.tx_busy;
  assign out_ch.rx_busy             = res_held.rx_busy;
  assign out_ch.rx_valid            = res_held.rx_valid;
  assign out_ch.rx_byte             = res_held.rx_byte;
  assign out_ch.parity_error        = res_held.parity_error;
  assign out_ch.parity_error_sticky = res_held.parity_error_sticky;

endmodule

FILE: src/u8e1_checker.sv
// Port-level checks for the UART top level, attached by bind.
// Depends on u8e1_pkg and uart_8e1_half_duplex.
`timescale 1ns / 1ps

module u8e1_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        tx_busy,
  input logic                        rx_busy,
  input logic                        rx_valid,
  input logic [u8e1_pkg::BYTE_W-1:0] rx_byte,
  input logic                        parity_error,
  input logic                        parity_error_sticky
);
  import u8e1_pkg::*;

  // Empty result register after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // Half duplex: never transmitting and receiving at once
  a_half_duplex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(tx_busy && rx_busy))
    else $error("tx_busy and rx_busy both set");

  // A completed byte ends the receive frame; its error also sets the sticky flag
  a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && parity_error |-> rx_valid && !rx_busy && parity_error_sticky)
    else $error("parity error outside a completed byte");

  // Sticky flag never drops between consecutive result words
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && parity_error_sticky && in_valid && in_ready
    |=> out_valid && parity_error_sticky)
    else $error("sticky parity error cleared");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rx_byte))
    else $error("stalled result word changed");

endmodule

bind uart_8e1_half_duplex u8e1_checker u_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .tx_busy             (out_ch.tx_busy),
  .rx_busy             (out_ch.rx_busy),
  .rx_valid            (out_ch.rx_valid),
  .rx_byte             (out_ch.rx_byte),
  .parity_error        (out_ch.parity_error),
  .parity_error_sticky (out_ch.parity_error_sticky)
);
